// ===== sv/otsa_pkg.sv =====
// ============================================================================
// otsa_pkg
// Shared types and constants for the owner tagged slot allocator.
// ============================================================================
package otsa_pkg;

    localparam int POOL_SLOTS  = 64;
    localparam int SLOT_W      = 6;
    localparam int TAG_W       = 48;
    localparam int COUNT_W     = 7;
    localparam int STATUS_W    = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(POOL_SLOTS - 1);
    localparam logic [COUNT_W:0]   POOL_LIMIT = (COUNT_W + 1)'(POOL_SLOTS);
    localparam logic [QCNT_W-1:0]  QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

    // request opcodes
    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_ROOM   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_COUNT = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [TAG_W-1:0]   owner_tag;
        logic [COUNT_W-1:0] want_count;
        logic [63:0]        release_mask;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   granted_slot;
        logic [COUNT_W-1:0]  outstanding;
        logic                last_result;
    } out_word_t;

    // request class decided at the front
    typedef enum logic [1:0] {
        K_ACQUIRE,
        K_RELEASE,
        K_BAD_COUNT,
        K_INVALID
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [TAG_W-1:0]   owner_tag;
        logic [COUNT_W-1:0] want_count;
        logic [63:0]        release_mask;
    } req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACQ,
        S_REL,
        S_REL_DONE
    } state_t;

    function automatic out_word_t mk_result(logic [STATUS_W-1:0] status,
                                            logic [SLOT_W-1:0]   slot,
                                            logic [COUNT_W-1:0]  outst,
                                            logic                last);
        out_word_t r;
        r.status       = status;
        r.granted_slot = slot;
        r.outstanding  = outst;
        r.last_result  = last;
        return r;
    endfunction

endpackage

// ===== sv/otsa_front.sv =====
// ============================================================================
// otsa_front
// Accepts request words, classifies them and holds them in a short queue.
// ============================================================================
module otsa_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  otsa_pkg::in_word_t s_word,
    output logic               q_valid,
    output otsa_pkg::req_t     q_req,
    input  logic               q_pop
);

    otsa_pkg::req_t                   fifo_reg [otsa_pkg::QUEUE_DEPTH];
    logic [otsa_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [otsa_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [otsa_pkg::QCNT_W-1:0]      count_reg, count_next;
    otsa_pkg::req_t                   req_in;
    logic                             push;
    logic                             pop;

    // classify
    always_comb begin
        req_in.owner_tag    = s_word.owner_tag;
        req_in.want_count   = s_word.want_count;
        req_in.release_mask = s_word.release_mask;
        case (s_word.opcode)
            otsa_pkg::OP_ACQUIRE: begin
                if (s_word.want_count == '0) begin
                    req_in.kind = otsa_pkg::K_BAD_COUNT;
                end else begin
                    req_in.kind = otsa_pkg::K_ACQUIRE;
                end
            end
            otsa_pkg::OP_RELEASE: begin
                req_in.kind = otsa_pkg::K_RELEASE;
            end
            default: begin
                req_in.kind = otsa_pkg::K_INVALID;
            end
        endcase
    end

    assign s_ready = (count_reg != otsa_pkg::QUEUE_FULL);
    assign q_valid = (count_reg != '0);
    assign q_req   = fifo_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= req_in;
        end
    end

endmodule

// ===== sv/otsa_back.sv =====
// ============================================================================
// otsa_back
// Executes queued requests: slot scan, owner store and result register.
// ============================================================================
module otsa_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  otsa_pkg::req_t      q_req,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output otsa_pkg::out_word_t m_word
);

    otsa_pkg::state_t                  state_reg, state_next;
    logic [otsa_pkg::TAG_W-1:0]        cur_tag_reg, cur_tag_next;
    logic [63:0]                       cur_mask_reg, cur_mask_next;
    logic [otsa_pkg::COUNT_W-1:0]      left_reg, left_next;
    logic [otsa_pkg::SLOT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                              issue_done_reg, issue_done_next;
    logic                              chk_valid_reg, chk_valid_next;
    logic [otsa_pkg::SLOT_W-1:0]       chk_idx_reg, chk_idx_next;
    logic [otsa_pkg::STATUS_W-1:0]     rel_status_reg, rel_status_next;
    logic [otsa_pkg::POOL_SLOTS-1:0]   held_reg, held_next;
    logic [otsa_pkg::COUNT_W-1:0]      held_count_reg, held_count_next;
    logic                              m_valid_reg, m_valid_next;
    otsa_pkg::out_word_t               m_word_reg, m_word_next;

    logic [otsa_pkg::TAG_W-1:0]        owner_mem [otsa_pkg::POOL_SLOTS];
    logic [otsa_pkg::TAG_W-1:0]        rd_data_reg;
    logic                              mem_we;

    logic                              out_free;
    logic [otsa_pkg::COUNT_W:0]        acq_sum;
    logic                              chk_hit;

    assign out_free = !m_valid_reg || m_ready;
    assign acq_sum  = {1'b0, held_count_reg} + {1'b0, q_req.want_count};
    assign chk_hit  = chk_valid_reg && cur_mask_reg[chk_idx_reg] && held_reg[chk_idx_reg];

    always_comb begin
        state_next      = state_reg;
        cur_tag_next    = cur_tag_reg;
        cur_mask_next   = cur_mask_reg;
        left_next       = left_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        rel_status_next = rel_status_reg;
        held_next       = held_reg;
        held_count_next = held_count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_word_next     = m_word_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;

        case (state_reg)
            otsa_pkg::S_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    case (q_req.kind)
                        otsa_pkg::K_ACQUIRE: begin
                            if (acq_sum > otsa_pkg::POOL_LIMIT) begin
                                m_valid_next = 1'b1;
                                m_word_next  = otsa_pkg::mk_result(otsa_pkg::STAT_NO_ROOM,
                                                   '0, held_count_reg, 1'b1);
                            end else begin
                                cur_tag_next  = q_req.owner_tag;
                                left_next     = q_req.want_count;
                                scan_idx_next = '0;
                                state_next    = otsa_pkg::S_ACQ;
                            end
                        end
                        otsa_pkg::K_RELEASE: begin
                            cur_tag_next    = q_req.owner_tag;
                            cur_mask_next   = q_req.release_mask;
                            scan_idx_next   = '0;
                            issue_done_next = 1'b0;
                            chk_valid_next  = 1'b0;
                            state_next      = otsa_pkg::S_REL;
                        end
                        otsa_pkg::K_BAD_COUNT: begin
                            m_valid_next = 1'b1;
                            m_word_next  = otsa_pkg::mk_result(otsa_pkg::STAT_BAD_COUNT,
                                               '0, held_count_reg, 1'b1);
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_word_next  = otsa_pkg::mk_result(otsa_pkg::STAT_INVALID,
                                               '0, held_count_reg, 1'b1);
                        end
                    endcase
                end
            end
            otsa_pkg::S_ACQ: begin
                if (held_reg[scan_idx_reg]) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end else if (out_free) begin
                    mem_we                  = 1'b1;
                    held_next[scan_idx_reg] = 1'b1;
                    held_count_next         = held_count_reg + 1'b1;
                    left_next               = left_reg - 1'b1;
                    scan_idx_next           = scan_idx_reg + 1'b1;
                    m_valid_next            = 1'b1;
                    m_word_next = otsa_pkg::mk_result(otsa_pkg::STAT_OK, scan_idx_reg,
                                      held_count_reg + 1'b1, (left_reg == 7'd1));
                    if (left_reg == 7'd1) begin
                        state_next = otsa_pkg::S_IDLE;
                    end
                end
            end
            otsa_pkg::S_REL: begin
                if (chk_hit && (rd_data_reg != cur_tag_reg)) begin
                    // foreign owner: stop the walk, earlier frees stand
                    chk_valid_next  = 1'b0;
                    rel_status_next = otsa_pkg::STAT_MISMATCH;
                    state_next      = otsa_pkg::S_REL_DONE;
                end else begin
                    if (chk_hit) begin
                        held_next[chk_idx_reg] = 1'b0;
                        if (held_count_reg != '0) begin
                            held_count_next = held_count_reg - 1'b1;
                        end
                    end
                    if (!issue_done_reg) begin
                        chk_valid_next = 1'b1;
                        chk_idx_next   = scan_idx_reg;
                        scan_idx_next  = scan_idx_reg + 1'b1;
                        if (scan_idx_reg == otsa_pkg::LAST_SLOT) begin
                            issue_done_next = 1'b1;
                        end
                    end else begin
                        chk_valid_next  = 1'b0;
                        rel_status_next = otsa_pkg::STAT_OK;
                        state_next      = otsa_pkg::S_REL_DONE;
                    end
                end
            end
            otsa_pkg::S_REL_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = otsa_pkg::mk_result(rel_status_reg, '0,
                                       held_count_reg, 1'b1);
                    state_next   = otsa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = otsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= otsa_pkg::S_IDLE;
            issue_done_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            held_reg       <= '0;
            held_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            chk_valid_reg  <= chk_valid_next;
            held_reg       <= held_next;
            held_count_reg <= held_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_tag_reg    <= cur_tag_next;
        cur_mask_reg   <= cur_mask_next;
        left_reg       <= left_next;
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= chk_idx_next;
        rel_status_reg <= rel_status_next;
        m_word_reg     <= m_word_next;
    end

    // owner store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            owner_mem[scan_idx_reg] <= cur_tag_reg;
        end
        rd_data_reg <= owner_mem[scan_idx_reg];
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// ===== sv/owner_tagged_slot_allocator_top.sv =====
// ============================================================================
// owner_tagged_slot_allocator_top
// Pool of 64 slots, each free or held by a 48-bit owner tag.
// ============================================================================
// Requests (acquire, release, anything else) enter through a two-word queue
// and are executed one at a time. An acquire of N slots scans the pool from
// slot 0, one slot per cycle while the result side takes its words, and
// returns one word per granted slot. A release walks all 64 slots through
// the owner store's registered read port, one slot per cycle, and returns a
// single word when the walk ends, early if it meets a slot held by another
// owner. Bad counts, requests too large for the free space and unknown
// opcodes return a single word in the cycle after they leave the queue.
// The owner store's single read port sets the release walk at one slot per
// cycle. Results sit in an output register, so a stalled result side holds
// an acquire scan at its next free slot and a release at its final word,
// but the queue keeps taking requests until it is full.
// ============================================================================
module owner_tagged_slot_allocator_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  otsa_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output otsa_pkg::out_word_t m_word
);

    logic           q_valid;
    logic           q_pop;
    otsa_pkg::req_t q_req;

    // front: accept and classify words
    otsa_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop)
    );

    // back: slot scan, owner store and result register
    otsa_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

`ifndef NO_ASSERTIONS
    // held count never exceeds the pool
    a_outstanding_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.outstanding <= 7'(otsa_pkg::POOL_SLOTS)))
        else $error("outstanding count above pool size");

    // any non-grant answer is a single, final word with slot zero
    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_word.status != otsa_pkg::STAT_OK || !m_word.last_result
                     || m_word.granted_slot != '0) && m_word.status != otsa_pkg::STAT_OK)
        |-> (m_word.last_result && m_word.granted_slot == '0))
        else $error("error result not a single final word");

    // an intermediate grant is never the top slot
    a_grant_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.status == otsa_pkg::STAT_OK && !m_word.last_result)
        |-> (m_word.granted_slot != otsa_pkg::LAST_SLOT))
        else $error("non-final grant at top slot");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule
